// ===== sv/eqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Equirectangular distance package
// Shared constants, fixed-point widths and the buses between the cells.
// ----------------------------------------------------------------------------
package eqd_pkg;

	localparam int unsigned COS_TERMS_DEF = 6;
	localparam int unsigned SQRT_STEPS    = 32;

	localparam logic [24:0] RAD_K        = 25'd31441057;
	localparam logic [22:0] RADIUS_RESET = 23'd6371000;
	localparam logic [29:0] R100_RESET   = 30'd637100000;
	localparam logic [32:0] DIST_MAX     = 33'd4500000000;
	localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

	localparam int unsigned IN_W   = 128;
	localparam int unsigned OUT_W  = 40;
	localparam int unsigned DIST_W = 33;
	localparam int unsigned CFG_W  = 23;

	typedef struct packed {
		logic               valid;
		logic [31:0]        x2;
		logic [31:0]        term;
		logic signed [35:0] sum;
		logic [30:0]        a;
		logic [30:0]        b;
	} cos_bus_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_bus_t;

endpackage

// ===== sv/equirectangular_distance.sv =====
// ----------------------------------------------------------------------------
// Equirectangular distance
// Distance in centimetres between two positions given in 1e-7 degree units.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the skid stage is empty; the skid stage
// takes one more result while m_tready is low, and s_tready stays low until it drains.
// The datapath runs through the cosine cell row and then the 32-cell root row.
// Reset: arst_n clears all valid bits and loads the radius with 6371000 m.
module equirectangular_distance #(
	parameter int unsigned COS_TERMS = eqd_pkg::COS_TERMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94], zero fill
	input  logic [eqd_pkg::IN_W-1:0]         s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// distance_cm[32:0], zero fill
	output logic [eqd_pkg::OUT_W-1:0]        m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [eqd_pkg::CFG_W-1:0]        cfg_data
);

	localparam int unsigned CELLS = COS_TERMS - 1;

	logic en;
	logic [29:0] r100_q;

	logic signed [30:0] lat_a, lat_b;
	logic signed [31:0] lon_a, lon_b;
	logic signed [31:0] sum_lat, d_lat;
	logic signed [32:0] d_lon;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [31:0] msum_s1, mdlat_s1;
	logic [32:0] mdlon_s1;
	logic [30:0] mean_s2, a_s2, b_s2;
	logic [31:0] x2_s3;
	logic [30:0] a_s3, b_s3;
	logic [30:0] c_s4, a_s4, b_s4;
	logic [30:0] bc_s5;
	logic [61:0] asq_s5, asq_s6, bcsq_s6;
	logic [62:0] rad_s7;
	logic [61:0] prod_s8;
	logic [32:0] dist_s9;

	logic [56:0] mean_p, a_p;
	logic [57:0] b_p;
	logic [61:0] bc_p;
	logic [62:0] rnd;
	logic [32:0] cos_c;
	logic signed [35:0] cos_sum;

	logic        out_vld_q, skid_vld_q;
	logic [32:0] out_q, skid_q;
	logic        take;

	eqd_pkg::cos_bus_t  cos_bus  [0:CELLS];
	eqd_pkg::sqrt_bus_t sqrt_bus [0:eqd_pkg::SQRT_STEPS];

	assign en        = !skid_vld_q;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign take      = out_vld_q && m_tready;

	assign lat_a = s_tdata[30:0];
	assign lon_a = s_tdata[62:31];
	assign lat_b = s_tdata[93:63];
	assign lon_b = s_tdata[125:94];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r100_q   <= eqd_pkg::R100_RESET;
		end else if (cfg_valid) begin
			r100_q   <= 30'(cfg_data) * 30'd100;
		end
	end

	always_comb begin
		sum_lat = 32'(lat_a) + 32'(lat_b);
		d_lat   = 32'(lat_b) - 32'(lat_a);
		d_lon   = 33'(lon_b) - 33'(lon_a);
		mean_p  = 57'(msum_s1) * 57'(eqd_pkg::RAD_K) + (57'd1 << 24);
		a_p     = 57'(mdlat_s1) * 57'(eqd_pkg::RAD_K) + (57'd1 << 25);
		b_p     = 58'(mdlon_s1) * 58'(eqd_pkg::RAD_K) + (58'd1 << 25);
		cos_sum = cos_bus[CELLS].sum;
		if (cos_sum < 0) begin
			cos_c = '0;
		end else if (cos_sum > 36'sd1073741824) begin
			cos_c = 33'(eqd_pkg::ONE_Q30);
		end else begin
			cos_c = cos_sum[32:0];
		end
		bc_p = 62'(b_s4) * 62'(c_s4) + (62'd1 << 29);
		rnd  = 63'(prod_s8) + (63'd1 << 27);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= cos_bus[CELLS].valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= sqrt_bus[eqd_pkg::SQRT_STEPS].valid;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			msum_s1  <= (sum_lat < 0) ? 32'(-sum_lat) : 32'(sum_lat);
			mdlat_s1 <= (d_lat < 0) ? 32'(-d_lat) : 32'(d_lat);
			mdlon_s1 <= (d_lon < 0) ? 33'(-d_lon) : 33'(d_lon);
			mean_s2  <= mean_p[55:25];
			a_s2     <= a_p[56:26];
			b_s2     <= b_p[56:26];
			x2_s3    <= 32'((62'(mean_s2) * 62'(mean_s2)) >> 30);
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			c_s4     <= cos_c[30:0];
			a_s4     <= cos_bus[CELLS].a;
			b_s4     <= cos_bus[CELLS].b;
			bc_s5    <= bc_p[60:30];
			asq_s5   <= 62'(a_s4) * 62'(a_s4);
			bcsq_s6  <= 62'(bc_s5) * 62'(bc_s5);
			asq_s6   <= asq_s5;
			rad_s7   <= 63'(asq_s6) + 63'(bcsq_s6);
			prod_s8  <= 62'(sqrt_bus[eqd_pkg::SQRT_STEPS].root) * 62'(r100_q);
			dist_s9  <= (rnd[62:28] > 35'(eqd_pkg::DIST_MAX)) ? eqd_pkg::DIST_MAX
				: rnd[60:28];
		end
	end

	always_comb begin
		cos_bus[0].valid = vld_s3;
		cos_bus[0].x2    = x2_s3;
		cos_bus[0].term  = 32'(eqd_pkg::ONE_Q30);
		cos_bus[0].sum   = 36'sd1073741824;
		cos_bus[0].a     = a_s3;
		cos_bus[0].b     = b_s3;
		sqrt_bus[0].valid = vld_s7;
		sqrt_bus[0].rad   = {1'b0, rad_s7};
		sqrt_bus[0].rem   = '0;
		sqrt_bus[0].root  = '0;
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_cos
		eqd_cos_cell #(.N(i + 1)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_bus  (cos_bus[i]),
			.out_bus (cos_bus[i + 1])
		);
	end

	for (genvar j = 0; j < eqd_pkg::SQRT_STEPS; j++) begin : g_sqrt
		eqd_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_bus  (sqrt_bus[j]),
			.out_bus (sqrt_bus[j + 1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s9;
			end
		end else if (vld_s9 && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_vld_q ? skid_q : dist_s9;
		end else if (en) begin
			skid_q <= dist_s9;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, out_q};

endmodule

// ===== sv/eqd_cos_cell.sv =====
// ----------------------------------------------------------------------------
// Cosine series cell
// Computes one Taylor term from the previous one and adds it to the sum, or subtracts it for odd terms.
// ----------------------------------------------------------------------------
module eqd_cos_cell #(
	parameter int unsigned N = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  eqd_pkg::cos_bus_t in_bus,
	output eqd_pkg::cos_bus_t out_bus
);

	localparam int unsigned DIV_I = (2 * N - 1) * (2 * N);
	localparam logic [10:0] DIV   = 11'(DIV_I);
	localparam logic [32:0] RECIP = 33'((64'd1 << 33) / DIV_I);
	localparam logic        ODD   = 1'(N % 2);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	eqd_pkg::cos_bus_t bus_s1, bus_s2, bus_s3, bus_s4;
	logic [63:0] p_s1;
	logic [32:0] v_s2, v_s3;
	logic [65:0] pm_s2;
	logic [32:0] q0_s3;
	logic [43:0] qd_s3;

	logic [32:0] rem;
	logic [32:0] q;
	logic signed [35:0] sum_n;
	eqd_pkg::cos_bus_t bus_n;

	always_comb begin
		rem = v_s3 - qd_s3[32:0];
		q = (rem >= {22'b0, DIV}) ? q0_s3 + 33'd1 : q0_s3;
		if (ODD) begin
			sum_n = bus_s3.sum - $signed({4'b0, q[31:0]});
		end else begin
			sum_n = bus_s3.sum + $signed({4'b0, q[31:0]});
		end
		bus_n      = bus_s3;
		bus_n.term = q[31:0];
		bus_n.sum  = sum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_bus.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_s1 <= in_bus;
			p_s1   <= 64'(in_bus.term) * 64'(in_bus.x2);
			bus_s2 <= bus_s1;
			v_s2   <= p_s1[62:30];
			pm_s2  <= 66'(p_s1[62:30]) * 66'(RECIP);
			bus_s3 <= bus_s2;
			v_s3   <= v_s2;
			q0_s3  <= pm_s2[65:33];
			qd_s3  <= 44'(pm_s2[65:33]) * 44'(DIV);
			bus_s4 <= bus_n;
		end
	end

	always_comb begin
		out_bus = bus_s4;
		out_bus.valid = vld_s4;
	end

endmodule

// ===== sv/eqd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one bit of the integer square root per cell.
// ----------------------------------------------------------------------------
module eqd_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  eqd_pkg::sqrt_bus_t in_bus,
	output eqd_pkg::sqrt_bus_t out_bus
);

	logic        vld_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;

	logic [35:0] rem_n;
	logic [33:0] trial;
	logic        ge;

	always_comb begin
		rem_n = {in_bus.rem, in_bus.rad[63:62]};
		trial = {in_bus.root, 2'b01};
		ge = rem_n >= {2'b0, trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_bus.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {in_bus.rad[61:0], 2'b00};
			rem_q  <= ge ? 34'(rem_n - {2'b0, trial}) : rem_n[33:0];
			root_q <= {in_bus.root[30:0], ge};
		end
	end

	always_comb begin
		out_bus.valid = vld_q;
		out_bus.rad   = rad_q;
		out_bus.rem   = rem_q;
		out_bus.root  = root_q;
	end

endmodule

// ===== sv/eqd_checker.sv =====
// ----------------------------------------------------------------------------
// Equirectangular distance checker
// Port-level properties of the distance block, bound to the top level.
// ----------------------------------------------------------------------------
module eqd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [eqd_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [eqd_pkg::OUT_W-1:0] m_tdata,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [eqd_pkg::CFG_W-1:0] cfg_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[32:0] <= eqd_pkg::DIST_MAX)
		else $error("distance above saturation limit");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

endmodule

bind equirectangular_distance eqd_checker u_eqd_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Equirectangular distance testbench
// Drives coordinate pairs through the stream input under random idling, checks
// every distance against a fixed-point predictor or a table value and rewrites the
// radius between phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LATENCY = 4 * eqd_pkg::COS_TERMS_DEF + 38;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [eqd_pkg::IN_W-1:0]     s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [eqd_pkg::OUT_W-1:0]    m_tdata;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [eqd_pkg::CFG_W-1:0]    cfg_data;

	typedef struct {
		logic [30:0] lat_a;
		logic [31:0] lon_a;
		logic [30:0] lat_b;
		logic [31:0] lon_b;
		logic        known;
		logic [32:0] want;
	} coord_row_t;

	logic [22:0] radius_m;
	logic [32:0] dist_queue[$];
	int          errors;
	bit          hold_sink;
	bit          calm;

	equirectangular_distance u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [63:0] mag_of(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] root_of(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic logic [32:0] predict_distance(input logic [30:0] la,
			input logic [31:0] oa, input logic [30:0] lb, input logic [31:0] ob,
			input logic [22:0] rad);
		logic signed [63:0] sla, soa, slb, sob, sum;
		logic [63:0] mean, x2, term, a, b, bc, s, d;
		logic signed [63:0] cs;
		sla = {{33{la[30]}}, la};
		slb = {{33{lb[30]}}, lb};
		soa = {{32{oa[31]}}, oa};
		sob = {{32{ob[31]}}, ob};
		mean = (mag_of(sla + slb) * eqd_pkg::RAD_K + (64'd1 << 24)) >> 25;
		x2 = (mean * mean) >> 30;
		term = 64'd1 << 30;
		cs = 64'sd1 << 30;
		for (int n = 1; n < eqd_pkg::COS_TERMS_DEF; n++) begin
			term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
			if (n % 2) cs = cs - $signed(term);
			else cs = cs + $signed(term);
		end
		if (cs < 0) cs = 0;
		if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
		a = (mag_of(slb - sla) * eqd_pkg::RAD_K + (64'd1 << 25)) >> 26;
		b = (mag_of(sob - soa) * eqd_pkg::RAD_K + (64'd1 << 25)) >> 26;
		bc = (b * cs + (64'd1 << 29)) >> 30;
		s = root_of(a * a + bc * bc);
		d = (s * (rad * 64'd100) + (64'd1 << 27)) >> 28;
		if (d > eqd_pkg::DIST_MAX) d = eqd_pkg::DIST_MAX;
		return d[32:0];
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task automatic idle_gap();
		if (!calm) begin
			while ($urandom_range(99) < 34) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
	endtask

	task automatic send_request(input coord_row_t r);
		logic [32:0] pred;
		idle_gap();
		s_tdata  <= {2'b0, r.lon_b, r.lat_b, r.lon_a, r.lat_a};
		s_tvalid <= 1'b1;
		pred = predict_distance(r.lat_a, r.lon_a, r.lat_b, r.lon_b, radius_m);
		if (r.known && pred != r.want)
			report_mismatch($sformatf("predictor %0d vs table %0d", pred, r.want));
		do @(posedge clk); while (!s_tready);
		dist_queue.push_back(r.known ? r.want : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (dist_queue.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_radius(input logic [22:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		radius_m = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic coord_row_t random_row();
		coord_row_t r;
		r.known = 1'b0;
		r.want  = '0;
		if ($urandom_range(9) == 0) begin
			r.lat_a = 31'($urandom); r.lon_a = $urandom;
			r.lat_b = 31'($urandom); r.lon_b = $urandom;
		end else if ($urandom_range(2) == 0) begin
			r.lat_a = 31'($urandom_range(32'd1800000000) - 32'd900000000);
			r.lon_a = $urandom_range(32'd3600000000) - 32'd1800000000;
			r.lat_b = 31'(32'(r.lat_a) + $urandom_range(32'd2000000) - 32'd1000000);
			r.lon_b = r.lon_a + $urandom_range(32'd2000000) - 32'd1000000;
		end else begin
			r.lat_a = 31'($urandom_range(32'd1800000000) - 32'd900000000);
			r.lon_a = $urandom_range(32'd3600000000) - 32'd1800000000;
			r.lat_b = 31'($urandom_range(32'd1800000000) - 32'd900000000);
			r.lon_b = $urandom_range(32'd3600000000) - 32'd1800000000;
		end
		return r;
	endfunction

	always @(negedge clk) begin
		if (hold_sink) m_tready <= 1'b0;
		else if (calm) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_queue.size() == 0) begin
				report_mismatch("distance with no request pending");
			end else begin
				if (m_tdata[32:0] !== dist_queue[0])
					report_mismatch($sformatf("distance_cm %0d, want %0d",
						m_tdata[32:0], dist_queue[0]));
				if (m_tdata[eqd_pkg::OUT_W-1:33] !== '0)
					report_mismatch("nonzero fill in m_tdata");
				void'(dist_queue.pop_front());
			end
		end
	end

	coord_row_t directed[] = '{
		'{31'd0, 32'd0, 31'd0, 32'd0, 1'b1, 33'd0},
		'{31'd900000000, 32'd0, 31'd900000000, 32'd0, 1'b1, 33'd0},
		'{-31'sd900000000, 32'd1800000000, 31'd0, -32'sd1800000000, 1'b0, 33'd0},
		'{-31'sd900000000, 32'd0, 31'd900000000, 32'd0, 1'b0, 33'd0},
		'{31'd0, 32'h80000000, 31'd0, 32'h7fffffff, 1'b1, eqd_pkg::DIST_MAX},
		'{31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000, 1'b0, 33'd0},
		'{31'h40000000, 32'h80000000, 31'h40000000, 32'h7fffffff, 1'b0, 33'd0},
		'{31'h7fffffff, 32'hffffffff, 31'h7fffffff, 32'hffffffff, 1'b1, 33'd0},
		'{31'd0, 32'd0, 31'd1, 32'd1, 1'b0, 33'd0},
		'{31'd455000000, 32'd10000000, 31'd455000000, 32'd20000000, 1'b0, 33'd0},
		'{31'd899999999, 32'd0, 31'd899999999, 32'd1800000000, 1'b0, 33'd0},
		'{31'h40000000, 32'd0, 31'h40000000, 32'd1000, 1'b0, 33'd0},
		'{31'd123456789, -32'sd987654321, -31'sd22222222, 32'd55555555, 1'b0, 33'd0}
	};

	logic [22:0] radii[5] = '{23'd6000000, 23'd6500000, 23'h7fffff, 23'd0, 23'd6371000};

	initial begin
		coord_row_t r;
		errors = 0;
		hold_sink = 0;
		calm = 0;
		radius_m = eqd_pkg::RADIUS_RESET;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) send_request(directed[i]);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_radius(radii[p]);
			foreach (directed[i]) begin
				r = directed[i];
				r.known = 1'b0;
				send_request(r);
			end
			calm = (p == 2);
			for (int k = 0; k < 70; k++) send_request(random_row());
			calm = 0;
			if (p == 1) begin
				hold_sink = 1;
				fork
					begin
						repeat (LATENCY * 3) @(negedge clk);
						hold_sink = 0;
					end
					for (int k = 0; k < 80; k++) send_request(random_row());
				join
			end
			drain();
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
